FILE: design/websocket_frame_parser_top_assert.svh
// Assertion macros for the websocket frame parser.
`ifndef WEBSOCKET_FRAME_PARSER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define WSFP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wsfp assertion failed");

// Antecedent in this cycle implies consequent in this cycle.
`define WSFP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wsfp assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define WSFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wsfp assertion failed");

`else

`define WSFP_ASSERT_ALWAYS(lbl, cond)
`define WSFP_ASSERT_SAME(lbl, ante, cons)
`define WSFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/wsfp_pkg.sv
// Types, constants and opcode decode for the websocket frame parser.
package wsfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 64;
    localparam int CLASS_W     = 3;
    localparam int OUT_TDATA_W = 80;   // 77 bits of fields padded to whole bytes

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } t_phase;

    // Raw opcodes
    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    // Opcode classes as reported
    localparam logic [CLASS_W-1:0] CLS_CONT   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_TEXT   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_BINARY = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_CLOSE  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_PING   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_PONG   = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_OTHER  = 3'd6;

    // Header fields
    localparam int         FIN_BIT      = 7;
    localparam int         MASK_BIT     = 7;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [2:0] KEY_BYTES    = 3'd4;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    function automatic logic [CLASS_W-1:0] classify(input logic [3:0] code);
        logic [CLASS_W-1:0] cls;
        case (code)
            OPC_CONT:   cls = CLS_CONT;
            OPC_TEXT:   cls = CLS_TEXT;
            OPC_BINARY: cls = CLS_BINARY;
            OPC_CLOSE:  cls = CLS_CLOSE;
            OPC_PING:   cls = CLS_PING;
            OPC_PONG:   cls = CLS_PONG;
            default:    cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

FILE: design/websocket_frame_parser_top.sv
// Websocket frame parser: one raw byte in, one classified and unmasked byte out.
//
//  channel   dir  tdata (low bit up)                                  tuser      tlast
//  s_axis    in   raw byte [7:0]                                      -          -
//  m_axis    out  data[7:0] fin[8] class[11:9] mask[12] len[76:13]    kind[0]    frame end
//
// One byte per cycle sustained while m_axis_tready holds; each result appears in the cycle after its byte is taken.
// The header decode, key rotation and 64-bit payload countdown sit between the parse
// state and a single output register, which is all that sets the latency.
// Input is taken whenever the output register is empty or being drained this cycle.
// Synchronous active-low reset returns the parser to expect an opcode byte.
module websocket_frame_parser_top
    import wsfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // byte_in
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // data_out[7:0], fin_flag[8], opcode_class[11:9], masked_flag[12],
    // payload_length[76:13], zero[79:77]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // byte_kind
    output logic                   m_axis_tlast    // frame_end
);

`include "websocket_frame_parser_top_assert.svh"

    // Parse state
    t_phase                r_phase,        n_phase;
    logic                  r_fin,          n_fin;
    logic [CLASS_W-1:0]    r_class,        n_class;
    logic                  r_mask_bit,     n_mask_bit;
    logic [LEN_W-1:0]      r_length,       n_length;
    logic [3:0]            r_ext_left,     n_ext_left;
    logic [3:0][7:0]       r_mask_key,     n_mask_key;   // [3] is the first key byte
    logic [2:0]            r_key_left,     n_key_left;
    logic [LEN_W-1:0]      r_payload_left, n_payload_left;
    logic [1:0]            r_key_pos,      n_key_pos;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_kind,     n_out_kind;
    logic [BYTE_W-1:0]     r_out_data,     n_out_data;
    logic                  r_out_end,      n_out_end;

    logic                  in_accept;
    logic                  len_done;
    logic [6:0]            len_code;
    logic [3:0]            ext_dec;
    logic [2:0]            key_dec;
    logic [LEN_W-1:0]      payload_dec;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_phase        = r_phase;
        n_fin          = r_fin;
        n_class        = r_class;
        n_mask_bit     = r_mask_bit;
        n_length       = r_length;
        n_ext_left     = r_ext_left;
        n_mask_key     = r_mask_key;
        n_key_left     = r_key_left;
        n_payload_left = r_payload_left;
        n_key_pos      = r_key_pos;
        n_out_kind     = KIND_HEADER;
        n_out_data     = '0;
        n_out_end      = 1'b0;
        len_done       = 1'b0;
        len_code       = s_axis_tdata[6:0];
        ext_dec        = r_ext_left - 4'd1;
        key_dec        = r_key_left - 3'd1;
        payload_dec    = r_payload_left - LEN_W'(1);

        case (r_phase)
            PH_OPCODE: begin
                n_fin          = s_axis_tdata[FIN_BIT];
                n_class        = classify(s_axis_tdata[3:0]);
                n_mask_bit     = 1'b0;
                n_length       = '0;
                n_mask_key     = '0;
                n_key_pos      = '0;
                n_ext_left     = '0;
                n_key_left     = '0;
                n_payload_left = '0;
                n_phase        = PH_LEN;
            end
            PH_LEN: begin
                n_mask_bit = s_axis_tdata[MASK_BIT];
                if (len_code inside {LEN_CODE_16, LEN_CODE_64}) begin
                    n_ext_left = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    n_length   = '0;
                    n_phase    = PH_EXT;
                end else begin
                    n_length = LEN_W'(len_code);
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_length   = {r_length[LEN_W-9:0], s_axis_tdata};
                n_ext_left = ext_dec;
                len_done   = (ext_dec == 4'd0);
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[2:0], s_axis_tdata};
                n_key_left = key_dec;
                if (key_dec == 3'd0) begin
                    if (r_length != '0) begin
                        n_payload_left = r_length;
                        n_phase        = PH_DATA;
                    end else begin
                        n_phase   = PH_OPCODE;
                        n_out_end = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                n_out_kind     = KIND_PAYLOAD;
                n_out_data     = s_axis_tdata ^ r_mask_key[2'd3 - r_key_pos];
                n_key_pos      = r_key_pos + 2'd1;
                n_payload_left = payload_dec;
                if (payload_dec == '0) begin
                    n_phase   = PH_OPCODE;
                    n_out_end = 1'b1;
                end
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        // Length fully known: key next, payload next, or an empty frame ends here
        if (len_done) begin
            if (n_mask_bit) begin
                n_key_left = KEY_BYTES;
                n_phase    = PH_KEY;
            end else if (n_length != '0) begin
                n_payload_left = n_length;
                n_phase        = PH_DATA;
            end else begin
                n_phase   = PH_OPCODE;
                n_out_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_OPCODE;
            r_fin          <= 1'b0;
            r_class        <= CLS_OTHER;
            r_mask_bit     <= 1'b0;
            r_length       <= '0;
            r_ext_left     <= '0;
            r_mask_key     <= '0;
            r_key_left     <= '0;
            r_payload_left <= '0;
            r_key_pos      <= '0;
        end else if (in_accept) begin
            r_phase        <= n_phase;
            r_fin          <= n_fin;
            r_class        <= n_class;
            r_mask_bit     <= n_mask_bit;
            r_length       <= n_length;
            r_ext_left     <= n_ext_left;
            r_mask_key     <= n_mask_key;
            r_key_left     <= n_key_left;
            r_payload_left <= n_payload_left;
            r_key_pos      <= n_key_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
            r_out_end  <= n_out_end;
        end
    end

    // Header fields come straight from the parse state, which only moves on accept
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_end;
    assign m_axis_tdata  = {3'b000, r_length, r_mask_bit, r_class, r_fin, r_out_data};

    `WSFP_ASSERT_SAME(a_data_count_live, r_phase == PH_DATA, r_payload_left != '0)
    `WSFP_ASSERT_SAME(a_ext_count_live, r_phase == PH_EXT, r_ext_left != 4'd0)
    `WSFP_ASSERT_SAME(a_ext_count_max, r_phase == PH_EXT, r_ext_left <= EXT_BYTES_64)
    `WSFP_ASSERT_SAME(a_key_only_masked, r_phase == PH_KEY, r_mask_bit && (r_key_left != 3'd0))
    `WSFP_ASSERT_NEXT(a_opcode_to_len, in_accept && (r_phase == PH_OPCODE), r_phase == PH_LEN)
    `WSFP_ASSERT_SAME(a_header_zero_data, r_out_valid && (r_out_kind == KIND_HEADER), r_out_data == '0)

endmodule
